/* src/ngg_pkg.sv */
`timescale 1ns / 1ps
// Shared types, character codes and register indexes for the GGA longitude geofence.
// No dependencies; every other source file except ngg_stream_if imports this package.
package ngg_pkg;

  localparam int unsigned LINE_LIMIT = 100;
  localparam int unsigned POS_W      = 7;

  localparam logic [7:0] CH_DOLLAR  = 8'd36;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_G       = 8'd71;
  localparam logic [7:0] CH_A       = 8'd65;
  localparam logic [7:0] CH_DOT     = 8'd46;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;

  localparam int unsigned TYPE_POS = 3;
  localparam int unsigned TYPE_LEN = 3;
  localparam int unsigned LON_POS  = 30;
  localparam int unsigned LON_LEN  = 10;
  localparam int unsigned DOT_IDX  = 5;
  localparam int unsigned NUM_DIG  = 9;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LIMIT = 2'd2;

  localparam logic [7:0] DEGREE_LIMIT_RST = 8'd139;
  localparam logic [5:0] MINUTE_LIMIT_RST = 6'd47;
  localparam logic [5:0] SECOND_LIMIT_RST = 6'd44;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  lon_degrees;
    logic [6:0]  lon_minutes;
    logic [19:0] lon_seconds_e4;
    logic        takeover;
  } out_item_t;

  typedef struct packed {
    logic [7:0] degree_limit;
    logic [5:0] minute_limit;
    logic [5:0] second_limit;
  } limits_t;

  // Captured line characters as they stand after the current byte is stored
  typedef struct packed {
    logic [TYPE_LEN-1:0][7:0] type_chars;
    logic [LON_LEN-1:0][7:0]  lon_chars;
  } line_view_t;

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

endpackage

/* src/ngg_stream_if.sv */
`timescale 1ns / 1ps
// Valid/ready stream channel with a typed payload.
// Payload types come from ngg_pkg at the point of instantiation.
interface ngg_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* src/ngg_frame.sv */
`timescale 1ns / 1ps
// Input register and line framer: character position, kept characters, takeover latch.
// Depends on ngg_pkg and ngg_stream_if.
module ngg_frame #(
  parameter int unsigned LineLimit = ngg_pkg::LINE_LIMIT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ngg_stream_if.sink          rx_if,
  input  logic                out_free_i,
  input  logic                hit_i,
  output ngg_pkg::line_view_t view_o,
  output logic                emit_o
);
  import ngg_pkg::*;

  localparam logic [POS_W-1:0] LimitPos = POS_W'(LineLimit);

  logic                     pending_q, pending_d;
  logic [7:0]               byte_q;
  logic [POS_W-1:0]         pos_q, pos_d;
  logic [TYPE_LEN-1:0][7:0] type_q, type_d;
  logic [LON_LEN-1:0][7:0]  lon_q, lon_d;
  logic                     latched_q;
  logic                     active, store, eol, has_res, fire, accept;

  assign active = pending_q && !latched_q;
  assign store  = pos_q < LimitPos;
  assign eol    = active && (byte_q == CH_NEWLINE);

  always_comb begin
    type_d = type_q;
    lon_d  = lon_q;
    pos_d  = pos_q;
    if (active) begin
      for (int k = 0; k < TYPE_LEN; k++) begin
        if (store && (pos_q == POS_W'(TYPE_POS + k))) type_d[k] = byte_q;
      end
      for (int k = 0; k < LON_LEN; k++) begin
        if (store && (pos_q == POS_W'(LON_POS + k))) lon_d[k] = byte_q;
      end
      if (byte_q == CH_DOLLAR) begin
        pos_d = POS_W'(1);
      end else if (byte_q == CH_NEWLINE) begin
        pos_d = '0;
      end else if (store) begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  assign has_res = eol && (type_d[0] == CH_G) && (type_d[1] == CH_G) && (type_d[2] == CH_A);
  // Hold the byte only when it has a result and the output register is full and not taken
  assign fire     = pending_q && (!has_res || out_free_i);
  assign rx_if.ready = !pending_q || fire;
  assign accept   = rx_if.valid && rx_if.ready;

  always_comb begin
    pending_d = pending_q;
    if (accept) begin
      pending_d = 1'b1;
    end else if (fire) begin
      pending_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      pos_q     <= '0;
      type_q    <= '0;
      lon_q     <= '0;
      latched_q <= 1'b0;
    end else begin
      pending_q <= pending_d;
      if (fire) begin
        pos_q  <= pos_d;
        type_q <= type_d;
        lon_q  <= lon_d;
        if (has_res && hit_i) latched_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) byte_q <= rx_if.payload.rx_byte;
  end

  assign view_o.type_chars = type_d;
  assign view_o.lon_chars  = lon_d;
  assign emit_o            = fire && has_res;

endmodule

/* src/ngg_conv.sv */
`timescale 1ns / 1ps
// Longitude conversion: dddmm.mmmm characters to degrees, minutes, 1e-4 seconds, limit check.
// Depends on ngg_pkg.
module ngg_conv (
  input  ngg_pkg::line_view_t view_i,
  input  ngg_pkg::limits_t    limits_i,
  output ngg_pkg::out_item_t  result_o
);
  import ngg_pkg::*;

  logic [NUM_DIG-1:0][3:0] dig;
  logic                    ok;
  logic [9:0]              deg;
  logic [6:0]              mins;
  logic [13:0]             frac;
  logic [19:0]             sec;
  logic [19:0]             sec_lim;

  // First bad character zeroes itself and every later place
  always_comb begin
    ok  = 1'b1;
    dig = '0;
    for (int k = 0; k < DOT_IDX; k++) begin
      ok     = ok && is_digit(view_i.lon_chars[k]);
      dig[k] = ok ? view_i.lon_chars[k][3:0] : 4'd0;
    end
    ok = ok && (view_i.lon_chars[DOT_IDX] == CH_DOT);
    for (int k = 0; k < LON_LEN - DOT_IDX - 1; k++) begin
      ok               = ok && is_digit(view_i.lon_chars[DOT_IDX + 1 + k]);
      dig[DOT_IDX + k] = ok ? view_i.lon_chars[DOT_IDX + 1 + k][3:0] : 4'd0;
    end
  end

  assign deg  = 10'(dig[0]) * 10'd100 + 10'(dig[1]) * 10'd10 + 10'(dig[2]);
  assign mins = 7'(dig[3]) * 7'd10 + 7'(dig[4]);
  assign frac = 14'(dig[5]) * 14'd1000 + 14'(dig[6]) * 14'd100
              + 14'(dig[7]) * 14'd10 + 14'(dig[8]);
  assign sec     = 20'(frac) * 20'd60;
  assign sec_lim = 20'(limits_i.second_limit) * 20'd10000;

  assign result_o.lon_degrees    = deg;
  assign result_o.lon_minutes    = mins;
  assign result_o.lon_seconds_e4 = sec;
  assign result_o.takeover       = (deg >= 10'(limits_i.degree_limit))
                                && (mins >= 7'(limits_i.minute_limit))
                                && (sec > sec_lim);

endmodule

/* src/nmea_gga_longitude_geofence_core.sv */
`timescale 1ns / 1ps
// Top level of the GGA longitude geofence: limit registers, framer, converter, result register.
// Depends on ngg_pkg, ngg_stream_if, ngg_frame and ngg_conv.
//
//   channel  dir  payload                                                 transaction
//   rx_if    in   rx_byte[7:0]                                            valid & ready
//   res_if   out  lon_degrees[9:0] lon_minutes[6:0] lon_seconds_e4[19:0]  valid & ready
//                 takeover
//   cfg      in   cfg_we_i, cfg_idx_i[1:0], cfg_data_i[7:0]               cfg_we_i
//
// One byte per cycle while the input register is not holding a byte: a byte sits in the input
// register, where the framer updates the line state and the converter works on the freshly
// stored characters; its result lands in the output register as the byte leaves.
// Reset clears position, kept characters and the takeover latch and loads the limit defaults.
// A byte that ends a GGA line waits in the input register only while the output register
// is full and not taken; every other byte passes through regardless of the output side.
module nmea_gga_longitude_geofence_core #(
  parameter int unsigned LineLimit = ngg_pkg::LINE_LIMIT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  ngg_stream_if.sink                         rx_if,
  ngg_stream_if.source                       res_if,
  input  logic                               cfg_we_i,
  input  logic [ngg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ngg_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ngg_pkg::*;

  limits_t    limits_q;
  line_view_t view;
  out_item_t  conv_res;
  out_item_t  res_q;
  logic       res_valid_q;
  logic       out_free;
  logic       emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.degree_limit <= DEGREE_LIMIT_RST;
      limits_q.minute_limit <= MINUTE_LIMIT_RST;
      limits_q.second_limit <= SECOND_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEGREE_LIMIT: limits_q.degree_limit <= cfg_data_i;
        CFG_MINUTE_LIMIT: limits_q.minute_limit <= cfg_data_i[5:0];
        CFG_SECOND_LIMIT: limits_q.second_limit <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  assign out_free = !res_valid_q || res_if.ready;

  ngg_frame #(
    .LineLimit (LineLimit)
  ) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_if      (rx_if),
    .out_free_i (out_free),
    .hit_i      (conv_res.takeover),
    .view_o     (view),
    .emit_o     (emit)
  );

  ngg_conv u_conv (
    .view_i   (view),
    .limits_i (limits_q),
    .result_o (conv_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (emit) begin
      res_valid_q <= 1'b1;
    end else if (res_if.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) res_q <= conv_res;
  end

  assign res_if.valid   = res_valid_q;
  assign res_if.payload = res_q;

endmodule

/* verif/ngg_longitude_checker.sv */
`timescale 1ns / 1ps
// Checker for the GGA longitude geofence: tracks line framing, limit registers and the
// takeover latch, predicts each fix and compares it with the result channel.
// Depends on ngg_pkg.
module ngg_longitude_checker
  import ngg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rx_valid_i,
  input  logic                  rx_ready_i,
  input  in_item_t              rx_item_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  out_item_t             res_item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    fixes_due_o,
  output logic                  newline_latches_o
);

  typedef struct packed {
    logic [POS_W-1:0]         pos;
    logic [TYPE_LEN-1:0][7:0] sentence_id;
    logic [LON_LEN-1:0][7:0]  lon_text;
    logic                     latched;
  } line_track_t;

  line_track_t line_st;
  limits_t     limits;
  out_item_t   pending_fixes[$];
  int          errors = 0;
  int          due = 0;
  line_track_t peek_line;
  out_item_t   peek_fix;
  logic        peek_hit;

  // Frame one byte; return 1 when it closes a GGA line and yields a fix.
  function automatic logic take_byte(input line_track_t cur, input limits_t lim,
                                     input logic [7:0] ch, output line_track_t nxt,
                                     output out_item_t fix);
    int unsigned dig [NUM_DIG];
    int unsigned n, k, deg, mins, sec;
    logic        ok, fires, produced;
    logic [7:0]  c;
    nxt = cur;
    fix = '0;
    produced = 1'b0;
    n = 0;
    ok = 1'b1;
    if (!cur.latched) begin
      if (cur.pos < LINE_LIMIT) begin
        if (cur.pos >= TYPE_POS && cur.pos < TYPE_POS + TYPE_LEN) begin
          nxt.sentence_id[cur.pos - TYPE_POS] = ch;
        end
        if (cur.pos >= LON_POS && cur.pos < LON_POS + LON_LEN) begin
          nxt.lon_text[cur.pos - LON_POS] = ch;
        end
      end
      if (ch == CH_DOLLAR) begin
        nxt.pos = POS_W'(1);
      end else if (ch != CH_NEWLINE) begin
        if (cur.pos < LINE_LIMIT) nxt.pos = cur.pos + 1'b1;
      end else begin
        nxt.pos = '0;
        if (nxt.sentence_id[0] == CH_G && nxt.sentence_id[1] == CH_G &&
            nxt.sentence_id[2] == CH_A) begin
          for (k = 0; k < LON_LEN; k++) begin
            c = nxt.lon_text[k];
            if (k == DOT_IDX) begin
              if (c != CH_DOT) ok = 1'b0;
            end else begin
              // first character off the dddmm.mmmm layout zeroes the rest
              if (ok && !(c >= CH_ZERO && c <= CH_NINE)) ok = 1'b0;
              dig[n] = ok ? int'(c - CH_ZERO) : 0;
              n++;
            end
          end
          deg  = dig[0] * 100 + dig[1] * 10 + dig[2];
          mins = dig[3] * 10 + dig[4];
          sec  = (dig[5] * 1000 + dig[6] * 100 + dig[7] * 10 + dig[8]) * 60;
          fires = (deg >= lim.degree_limit) && (mins >= lim.minute_limit) &&
                  (sec > lim.second_limit * 10000);
          if (fires) nxt.latched = 1'b1;
          fix.lon_degrees    = deg[9:0];
          fix.lon_minutes    = mins[6:0];
          fix.lon_seconds_e4 = sec[19:0];
          fix.takeover       = fires;
          produced = 1'b1;
        end
      end
    end
    return produced;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    line_track_t nxt;
    out_item_t   fix;
    out_item_t   want;
    if (!rst_ni) begin
      line_st <= '0;
      limits  <= '{degree_limit: DEGREE_LIMIT_RST, minute_limit: MINUTE_LIMIT_RST,
                   second_limit: SECOND_LIMIT_RST};
      pending_fixes.delete();
      due = 0;
    end else begin
      // compare before queuing, so a fix is never matched in its own cycle
      if (res_valid_i && res_ready_i) begin
        if (pending_fixes.size() == 0) begin
          $error("result with no fix pending: deg %0d min %0d sec_e4 %0d takeover %0b",
                 res_item_i.lon_degrees, res_item_i.lon_minutes,
                 res_item_i.lon_seconds_e4, res_item_i.takeover);
          errors++;
        end else begin
          want = pending_fixes.pop_front();
          check_field("lon_degrees", want.lon_degrees, res_item_i.lon_degrees);
          check_field("lon_minutes", want.lon_minutes, res_item_i.lon_minutes);
          check_field("lon_seconds_e4", want.lon_seconds_e4, res_item_i.lon_seconds_e4);
          check_field("takeover", want.takeover, res_item_i.takeover);
        end
      end
      if (rx_valid_i && rx_ready_i) begin
        if (take_byte(line_st, limits, rx_item_i.rx_byte, nxt, fix)) begin
          pending_fixes.push_back(fix);
        end
        line_st <= nxt;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEGREE_LIMIT: limits.degree_limit <= cfg_data_i;
          CFG_MINUTE_LIMIT: limits.minute_limit <= cfg_data_i[5:0];
          CFG_SECOND_LIMIT: limits.second_limit <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      due = pending_fixes.size();
    end
  end

  // Would a newline accepted now latch takeover?
  always_comb begin
    peek_hit = take_byte(line_st, limits, CH_NEWLINE, peek_line, peek_fix);
  end

  assign newline_latches_o = peek_hit && peek_fix.takeover;
  assign fail_count_o      = errors;
  assign fixes_due_o       = due;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Top of the GGA longitude geofence testbench: clock, reset, byte stream stimulus,
// limit writes and the verdict. Depends on ngg_pkg, ngg_stream_if, the core and
// ngg_longitude_checker.
module testbench;
  import ngg_pkg::*;

  localparam logic [7:0] CH_COMMA = 8'd44;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    fixes_due;
  logic                  newline_latches;

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  logic        allow_latch = 1'b0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  int          fixes_seen = 0;
  int          bytes_sent = 0;
  int unsigned lim_deg = DEGREE_LIMIT_RST;
  int unsigned lim_min = MINUTE_LIMIT_RST;
  int unsigned lim_sec = SECOND_LIMIT_RST;
  logic [7:0]  line_buf[$];

  ngg_stream_if #(.payload_t(in_item_t))  rx_if ();
  ngg_stream_if #(.payload_t(out_item_t)) res_if ();

  initial begin
    rx_if.valid   = 1'b0;
    rx_if.payload = '0;
    res_if.ready  = 1'b0;
  end

  always #5 clk = ~clk;

  nmea_gga_longitude_geofence_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .rx_if      (rx_if),
    .res_if     (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  ngg_longitude_checker i_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .rx_valid_i        (rx_if.valid),
    .rx_ready_i        (rx_if.ready),
    .rx_item_i         (rx_if.payload),
    .res_valid_i       (res_if.valid),
    .res_ready_i       (res_if.ready),
    .res_item_i        (res_if.payload),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .fail_count_o      (fail_count),
    .fixes_due_o       (fixes_due),
    .newline_latches_o (newline_latches)
  );

  // Receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (res_if.valid && res_if.ready) fixes_seen++;
  end

  function automatic logic [7:0] filler_char();
    return 8'($urandom_range(44, 90));
  endfunction

  function automatic int unsigned near_value(input int unsigned center,
                                             input int unsigned ceil_v);
    int v;
    v = int'(center) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > int'(ceil_v)) v = ceil_v;
    return v;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    // keep takeover unlatched until the closing phase
    if (c == CH_NEWLINE && newline_latches && !allow_latch) c = CH_COMMA;
    if ($urandom_range(0, 99) < gap_pct) begin
      rx_if.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    rx_if.valid <= 1'b1;
    rx_if.payload.rx_byte <= c;
    do @(posedge clk); while (!(rx_if.valid && rx_if.ready));
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic push_digits(input int unsigned v, input int unsigned w);
    int unsigned scale;
    scale = 1;
    repeat (w - 1) scale *= 10;
    repeat (w) begin
      line_buf.push_back(CH_ZERO + 8'((v / scale) % 10));
      scale /= 10;
    end
  endtask

  task automatic pad_to(input int unsigned n);
    while (line_buf.size() < n) line_buf.push_back(filler_char());
  endtask

  // Line up to the longitude field; without '$' the line relies on position 0
  task automatic open_line(input string kind, input bit with_dollar);
    line_buf.delete();
    line_buf.push_back(with_dollar ? CH_DOLLAR : filler_char());
    push_text("GP");
    push_text(kind);
    pad_to(LON_POS);
  endtask

  task automatic send_line();
    line_buf.push_back(CH_NEWLINE);
    foreach (line_buf[i]) send_byte(line_buf[i]);
  endtask

  task automatic gga_fix(input string lon);
    open_line("GGA", 1'b1);
    push_text(lon);
    pad_to(line_buf.size() + 6);
    send_line();
  endtask

  task automatic drain();
    rx_if.valid <= 1'b0;
    @(negedge clk);
    while (fixes_due != 0) @(negedge clk);
    // a byte that yields nothing may still sit in the input register
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic set_limits(input logic [7:0] d, input logic [7:0] m, input logic [7:0] s);
    write_limit(CFG_DEGREE_LIMIT, d);
    write_limit(CFG_MINUTE_LIMIT, m);
    write_limit(CFG_SECOND_LIMIT, s);
    cfg_we <= 1'b0;
    lim_deg = d;
    lim_min = m[5:0];
    lim_sec = s[5:0];
  endtask

  task automatic random_line();
    int unsigned sel, deg, mins, frac, k;
    logic [7:0]  bad;
    string       kind;
    sel = $urandom_range(0, 99);
    if (sel < 85) begin
      if (sel < 68) begin
        kind = "GGA";
      end else begin
        case ($urandom_range(0, 3))
          0: kind = "RMC";
          1: kind = "GGB";
          2: kind = "AGA";
          default: kind = "GAA";
        endcase
      end
      deg  = $urandom_range(0, 1) ? $urandom_range(0, 999) : near_value(lim_deg, 999);
      mins = $urandom_range(0, 1) ? $urandom_range(0, 99) : near_value(lim_min, 99);
      case ($urandom_range(0, 3))
        0: frac = 0;
        1: frac = near_value(lim_sec * 10000 / 60, 9999);
        default: frac = $urandom_range(0, 9999);
      endcase
      open_line(kind, $urandom_range(0, 11) != 0);
      push_digits(deg, 3);
      push_digits(mins, 2);
      line_buf.push_back(CH_DOT);
      push_digits(frac, 4);
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(0, LON_LEN - 1);
        do bad = 8'($urandom_range(0, 255));
        while (bad == CH_DOLLAR || bad == CH_NEWLINE ||
               (k == DOT_IDX ? bad == CH_DOT : (bad >= CH_ZERO && bad <= CH_NINE)));
        line_buf[LON_POS + k] = bad;
      end
      case ($urandom_range(0, 9))
        0: while (line_buf.size() > $urandom_range(3, 39)) void'(line_buf.pop_back());
        1: pad_to($urandom_range(LINE_LIMIT, LINE_LIMIT + 40));
        default: pad_to(line_buf.size() + $urandom_range(0, 40));
      endcase
      send_line();
    end else begin
      repeat ($urandom_range(1, 24)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input int unsigned gap, input int unsigned stall,
                           input logic [7:0] d, input logic [7:0] m, input logic [7:0] s,
                           input bit hold);
    int b0, f0;
    drain();
    set_limits(d, m, s);
    gap_pct = gap;
    stall_pct = stall;
    if (hold) hold_req = 1'b1;
    b0 = bytes_sent;
    f0 = fixes_seen;
    while (bytes_sent - b0 < 48 || fixes_seen - f0 < 1) random_line();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed lines under the reset limits
    gga_fix("00000.0000");
    gga_fix("13947.7333");
    gga_fix("13946.9999");
    gga_fix("13847.9999");
    gga_fix("13947x1234");
    gga_fix("1a947.1234");
    gga_fix("13947.12a4");
    open_line("RMC", 1'b1);
    push_text("18000.0000");
    send_line();
    // short line: newline lands inside the longitude, the rest is stale
    open_line("GGA", 1'b1);
    push_text("1800");
    send_line();
    open_line("GGA", 1'b1);
    push_text("12345.6789");
    pad_to(LINE_LIMIT + 20);
    send_line();
    open_line("GGA", 1'b0);
    push_text("05501.0001");
    send_line();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_DOLLAR);
    repeat (5) send_byte(filler_char());
    gga_fix("01234.5678");
    drain();
    set_limits(8'hFF, 8'hFF, 8'hFF);
    gga_fix("99999.9999");

    run_phase(0, 0, 8'($urandom_range(0, 180)), 8'($urandom_range(0, 59)),
              8'($urandom_range(0, 59)), 1'b0);
    run_phase(62, 0, 8'd0, 8'd0, 8'd0, 1'b0);
    run_phase(0, 62, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 1'b0);
    run_phase(7, 7, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    run_phase(0, 0, 8'd180, 8'd59, 8'd59, 1'b1);
    run_phase(62, 62, 8'($urandom_range(0, 180)), 8'($urandom_range(0, 59)),
              8'($urandom_range(0, 59)), 1'b0);

    // latch takeover just past the boundary, then everything is ignored
    drain();
    set_limits(DEGREE_LIMIT_RST, MINUTE_LIMIT_RST, SECOND_LIMIT_RST);
    gap_pct = 0;
    stall_pct = 0;
    allow_latch = 1'b1;
    gga_fix("13947.7334");
    gga_fix("00000.0000");
    repeat (2) random_line();

    drain();
    repeat (6) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
src/ngg_pkg.sv
src/ngg_stream_if.sv
src/ngg_frame.sv
src/ngg_conv.sv
src/nmea_gga_longitude_geofence_core.sv
verif/ngg_longitude_checker.sv
verif/testbench.sv
